>>> hw/rtl/pre_pkg.sv
package pre_pkg;

    // Store geometry.
    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int SIDX_W  = LEN_W + 1;
    localparam int RADDR_W = ADDR_W + 1;

    // Field widths of the item channels.
    localparam int CH_W   = 8;
    localparam int POS_W  = 11;
    localparam int ODD_W  = 9;
    localparam int EVEN_W = 10;
    localparam int RAD_W  = EVEN_W;
    localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Signed index constants for the scan arithmetic.
    localparam logic signed [SIDX_W-1:0] SZERO = '0;
    localparam logic signed [SIDX_W-1:0] SONE  = SIDX_W'(1);
    localparam logic signed [SIDX_W-1:0] SMONE = '1;

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Radii store halves.
    localparam logic HALF_ODD  = 1'b0;
    localparam logic HALF_EVEN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITER,
        ST_MIR,
        ST_EXT_RD,
        ST_EXT_CMP,
        ST_WR,
        ST_Q_ODD,
        ST_Q_EVEN,
        ST_Q_CAP
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CH_W-1:0]   data;
    } char_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } char_rd_t;

    typedef struct packed {
        logic               we;
        logic [RADDR_W-1:0] addr;
        logic [RAD_W-1:0]   data;
    } radii_wr_t;

    typedef struct packed {
        logic               re;
        logic [RADDR_W-1:0] addr;
    } radii_rd_t;

endpackage

>>> hw/rtl/pre_char_mem.sv
module pre_char_mem (
    input  logic                       clk,
    input  pre_pkg::char_wr_t          wr,
    input  pre_pkg::char_rd_t          rd,
    output logic [pre_pkg::CH_W-1:0]   q_a,
    output logic [pre_pkg::CH_W-1:0]   q_b
);

    logic [pre_pkg::CH_W-1:0] mem [pre_pkg::MAX_LEN];

    // Single write port for appended bytes.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Two registered read ports; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            q_a <= mem[rd.addr_a];
            q_b <= mem[rd.addr_b];
        end
    end

endmodule

>>> hw/rtl/pre_radii_mem.sv
module pre_radii_mem (
    input  logic                        clk,
    input  pre_pkg::radii_wr_t          wr,
    input  pre_pkg::radii_rd_t          rd,
    output logic [pre_pkg::RAD_W-1:0]   q
);

    // Lower half holds odd radii, upper half holds even radii.
    logic [pre_pkg::RAD_W-1:0] mem [2 * pre_pkg::MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            q <= mem[rd.addr];
        end
    end

endmodule

>>> hw/rtl/pre_ctrl.sv
module pre_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic                          restart,
    input  logic [pre_pkg::CH_W-1:0]      ch,
    input  logic [pre_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pre_pkg::ODD_W-1:0]     odd_radius,
    output logic [pre_pkg::EVEN_W-1:0]    even_radius,
    output logic                          position_valid,
    output logic                          overflow,
    output pre_pkg::char_wr_t             char_wr,
    output pre_pkg::char_rd_t             char_rd,
    input  logic [pre_pkg::CH_W-1:0]      char_a,
    input  logic [pre_pkg::CH_W-1:0]      char_b,
    output pre_pkg::radii_wr_t            radii_wr,
    output pre_pkg::radii_rd_t            radii_rd,
    input  logic [pre_pkg::RAD_W-1:0]     radii_q
);

    pre_pkg::state_t state_reg, state_next;

    // Control state.
    logic [pre_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      dropped_reg, dropped_next;
    logic                      current_reg, current_next;
    logic                      out_valid_reg, out_valid_next;

    // Scan and result payload.
    logic                              pass_reg, pass_next;
    logic [pre_pkg::LEN_W-1:0]         i_reg, i_next;
    logic signed [pre_pkg::SIDX_W-1:0] k_reg, k_next;
    logic signed [pre_pkg::SIDX_W-1:0] lo_reg, lo_next;
    logic signed [pre_pkg::SIDX_W-1:0] hi_reg, hi_next;
    logic [pre_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [pre_pkg::ODD_W-1:0]         odd_reg, odd_next;
    logic [pre_pkg::ODD_W-1:0]         odd_out_reg, odd_out_next;
    logic [pre_pkg::EVEN_W-1:0]        even_out_reg, even_out_next;
    logic                              pvalid_out_reg, pvalid_out_next;
    logic                              ovf_out_reg, ovf_out_next;

    // Shared combinational terms.
    logic                              accept;
    logic                              slot_free;
    logic [pre_pkg::LEN_W-1:0]         eff_len;
    logic                              room;
    logic                              scan_done;
    logic                              in_box;
    logic signed [pre_pkg::SIDX_W-1:0] i_s, n_s, e_s, m_s;
    logic signed [pre_pkg::SIDX_W-1:0] left_s, right_s, mirror_s, bound_s, reach_s;
    logic                              ext_ok;
    logic                              pos_lt, pos_le;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign eff_len   = restart ? '0 : len_reg;
    assign room      = eff_len < pre_pkg::LEN_W'(pre_pkg::MAX_LEN);
    assign scan_done = (i_reg == len_reg);

    // Index arithmetic of the scan. The even pass shifts the right side by one.
    assign i_s      = signed'(pre_pkg::SIDX_W'(i_reg));
    assign n_s      = signed'(pre_pkg::SIDX_W'(len_reg));
    assign e_s      = signed'(pre_pkg::SIDX_W'(pass_reg));
    assign m_s      = signed'(pre_pkg::SIDX_W'(radii_q));
    assign in_box   = (i_s <= hi_reg);
    assign left_s   = i_s - k_reg - pre_pkg::SONE;
    assign right_s  = i_s + k_reg + pre_pkg::SONE - e_s;
    assign mirror_s = lo_reg + hi_reg - i_s + e_s;
    assign bound_s  = hi_reg - i_s + e_s;
    assign reach_s  = i_s + k_reg - e_s;
    assign ext_ok   = !left_s[pre_pkg::SIDX_W-1] && (right_s < n_s);

    assign pos_lt = pre_pkg::CMP_W'(pos_reg) < pre_pkg::CMP_W'(len_reg);
    assign pos_le = pre_pkg::CMP_W'(pos_reg) <= pre_pkg::CMP_W'(len_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pre_pkg::ST_IDLE:
            begin
                if (accept && (cmd == pre_pkg::CMD_QUERY))
                begin
                    state_next = current_reg ? pre_pkg::ST_Q_ODD : pre_pkg::ST_ITER;
                end
            end
            pre_pkg::ST_ITER:
            begin
                if (scan_done)
                begin
                    state_next = pass_reg ? pre_pkg::ST_Q_ODD : pre_pkg::ST_ITER;
                end
                else if (in_box)
                begin
                    state_next = pre_pkg::ST_MIR;
                end
                else
                begin
                    state_next = pre_pkg::ST_EXT_RD;
                end
            end
            pre_pkg::ST_MIR:     state_next = pre_pkg::ST_EXT_RD;
            pre_pkg::ST_EXT_RD:  state_next = ext_ok ? pre_pkg::ST_EXT_CMP : pre_pkg::ST_WR;
            pre_pkg::ST_EXT_CMP: state_next = (char_a == char_b) ? pre_pkg::ST_EXT_RD
                                                                 : pre_pkg::ST_WR;
            pre_pkg::ST_WR:      state_next = pre_pkg::ST_ITER;
            pre_pkg::ST_Q_ODD:   state_next = pre_pkg::ST_Q_EVEN;
            pre_pkg::ST_Q_EVEN:  state_next = pre_pkg::ST_Q_CAP;
            pre_pkg::ST_Q_CAP:   state_next = slot_free ? pre_pkg::ST_IDLE : pre_pkg::ST_Q_CAP;
            default:             state_next = pre_pkg::ST_IDLE;
        endcase
    end

    // Memory requests and handshake outputs.
    always_comb
    begin
        in_ready       = (state_reg == pre_pkg::ST_IDLE);
        char_wr.we     = 1'b0;
        char_wr.addr   = eff_len[pre_pkg::ADDR_W-1:0];
        char_wr.data   = ch;
        char_rd.re     = 1'b0;
        char_rd.addr_a = left_s[pre_pkg::ADDR_W-1:0];
        char_rd.addr_b = right_s[pre_pkg::ADDR_W-1:0];
        radii_wr.we    = 1'b0;
        radii_wr.addr  = {pass_reg, i_reg[pre_pkg::ADDR_W-1:0]};
        radii_wr.data  = k_reg[pre_pkg::RAD_W-1:0];
        radii_rd.re    = 1'b0;
        radii_rd.addr  = {pass_reg, mirror_s[pre_pkg::ADDR_W-1:0]};
        unique case (state_reg)
            pre_pkg::ST_IDLE:
            begin
                char_wr.we = accept && (cmd == pre_pkg::CMD_APPEND) && room;
            end
            pre_pkg::ST_ITER:
            begin
                radii_rd.re = !scan_done && in_box;
            end
            pre_pkg::ST_EXT_RD:
            begin
                char_rd.re = ext_ok;
            end
            pre_pkg::ST_WR:
            begin
                radii_wr.we = 1'b1;
            end
            pre_pkg::ST_Q_ODD:
            begin
                radii_rd.re   = 1'b1;
                radii_rd.addr = {pre_pkg::HALF_ODD, pre_pkg::ADDR_W'(pos_reg)};
            end
            pre_pkg::ST_Q_EVEN:
            begin
                radii_rd.re   = 1'b1;
                radii_rd.addr = {pre_pkg::HALF_EVEN, pre_pkg::ADDR_W'(pos_reg)};
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        len_next        = len_reg;
        dropped_next    = dropped_reg;
        current_next    = current_reg;
        out_valid_next  = out_valid_reg;
        pass_next       = pass_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        odd_next        = odd_reg;
        odd_out_next    = odd_out_reg;
        even_out_next   = even_out_reg;
        pvalid_out_next = pvalid_out_reg;
        ovf_out_next    = ovf_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pre_pkg::ST_IDLE:
            begin
                if (accept && (cmd == pre_pkg::CMD_APPEND))
                begin
                    // Append: a full store drops the byte and raises the flag.
                    if (restart)
                    begin
                        dropped_next = 1'b0;
                    end
                    if (room)
                    begin
                        len_next = eff_len + pre_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        len_next     = eff_len;
                        dropped_next = 1'b1;
                    end
                    current_next = 1'b0;
                end
                else if (accept)
                begin
                    pos_next  = position;
                    pass_next = 1'b0;
                    i_next    = '0;
                    lo_next   = pre_pkg::SZERO;
                    hi_next   = pre_pkg::SMONE;
                end
            end
            pre_pkg::ST_ITER:
            begin
                if (scan_done)
                begin
                    if (pass_reg)
                    begin
                        current_next = 1'b1;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                        i_next    = '0;
                        lo_next   = pre_pkg::SZERO;
                        hi_next   = pre_pkg::SMONE;
                    end
                end
                else if (!in_box)
                begin
                    k_next = pre_pkg::SZERO;
                end
            end
            pre_pkg::ST_MIR:
            begin
                // Mirror radius, clipped to the right edge of the known palindrome.
                k_next = (m_s < bound_s) ? m_s : bound_s;
            end
            pre_pkg::ST_EXT_CMP:
            begin
                if (char_a == char_b)
                begin
                    k_next = k_reg + pre_pkg::SONE;
                end
            end
            pre_pkg::ST_WR:
            begin
                if (reach_s > hi_reg)
                begin
                    lo_next = i_s - k_reg;
                    hi_next = reach_s;
                end
                i_next = i_reg + pre_pkg::LEN_W'(1);
            end
            pre_pkg::ST_Q_EVEN:
            begin
                odd_next = radii_q[pre_pkg::ODD_W-1:0];
            end
            pre_pkg::ST_Q_CAP:
            begin
                // The end position and beyond read as zero radii.
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    odd_out_next    = pos_lt ? odd_reg : '0;
                    even_out_next   = pos_lt ? radii_q[pre_pkg::EVEN_W-1:0] : '0;
                    pvalid_out_next = pos_le;
                    ovf_out_next    = dropped_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pre_pkg::ST_IDLE;
            len_reg       <= '0;
            dropped_reg   <= 1'b0;
            current_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            dropped_reg   <= dropped_next;
            current_reg   <= current_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pass_reg       <= pass_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        odd_reg        <= odd_next;
        odd_out_reg    <= odd_out_next;
        even_out_reg   <= even_out_next;
        pvalid_out_reg <= pvalid_out_next;
        ovf_out_reg    <= ovf_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign odd_radius     = odd_out_reg;
    assign even_radius    = even_out_reg;
    assign position_valid = pvalid_out_reg;
    assign overflow       = ovf_out_reg;

    // The string never grows past the store.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= pre_pkg::LEN_W'(pre_pkg::MAX_LEN))
        else $error("string length beyond store size");

    // A radius is written only inside the string and never reaches past its start.
    a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
        radii_wr.we |-> ((i_reg < len_reg) && !k_reg[pre_pkg::SIDX_W-1] && (k_reg <= i_s)))
        else $error("radius write out of range");

    // Table lookups for a query only start with tables that match the string.
    a_tables_current: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pre_pkg::ST_Q_ODD) |-> current_reg)
        else $error("query served from stale radii");

    // Any append invalidates the tables.
    a_append_stale: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == pre_pkg::CMD_APPEND)) |=> !current_reg)
        else $error("radii still marked current after append");

endmodule

>>> hw/rtl/palindrome_radius_engine_top.sv
// Palindrome radius engine.
// Input channel (in_valid/in_ready): cmd selects append or query. An append
// writes ch at the end of the string (restart empties the string and clears
// the overflow flag first); it gives no result. Appends
// to a full store are dropped and raise overflow.
// A query at position gives one transfer on the output channel
// (out_valid/out_ready): odd_radius, even_radius, position_valid, overflow.
// With radii tables current, a query reads the odd and even radii in ST_Q_ODD
// and ST_Q_EVEN, then registers the result in ST_Q_CAP and returns to idle.
// The first query after any append first rebuilds both tables in two scan
// passes; each position goes through ST_ITER, ST_MIR when it lies inside the
// known palindrome, ST_EXT_RD and ST_EXT_CMP for each character comparison,
// and ST_WR, which writes the radius.
// The scan speed is set by the single-entry radii store port and the character
// store, which are read once per step.
// The block works on one item at a time; an append may be accepted while a
// result waits. When the receiver stalls, a finished query holds in its last
// step until the output register is free.
// Reset empties the string, clears overflow and marks the tables stale; the
// memories are not cleared.
module palindrome_radius_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic                          restart,
    input  logic [pre_pkg::CH_W-1:0]      ch,
    input  logic [pre_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pre_pkg::ODD_W-1:0]     odd_radius,
    output logic [pre_pkg::EVEN_W-1:0]    even_radius,
    output logic                          position_valid,
    output logic                          overflow
);

    pre_pkg::char_wr_t         char_wr;
    pre_pkg::char_rd_t         char_rd;
    pre_pkg::radii_wr_t        radii_wr;
    pre_pkg::radii_rd_t        radii_rd;
    logic [pre_pkg::CH_W-1:0]  char_a;
    logic [pre_pkg::CH_W-1:0]  char_b;
    logic [pre_pkg::RAD_W-1:0] radii_q;

    // Sequencer: handshake, string bookkeeping and the radius scans.
    pre_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .restart        (restart),
        .ch             (ch),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .odd_radius     (odd_radius),
        .even_radius    (even_radius),
        .position_valid (position_valid),
        .overflow       (overflow),
        .char_wr        (char_wr),
        .char_rd        (char_rd),
        .char_a         (char_a),
        .char_b         (char_b),
        .radii_wr       (radii_wr),
        .radii_rd       (radii_rd),
        .radii_q        (radii_q)
    );

    // Character store.
    pre_char_mem u_char_mem (
        .clk (clk),
        .wr  (char_wr),
        .rd  (char_rd),
        .q_a (char_a),
        .q_b (char_b)
    );

    // Radii store, odd and even halves.
    pre_radii_mem u_radii_mem (
        .clk (clk),
        .wr  (radii_wr),
        .rd  (radii_rd),
        .q   (radii_q)
    );

endmodule

>>> verif/palindrome_radii_monitor.sv
module palindrome_radii_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       cmd,
    input  logic                       restart,
    input  logic [pre_pkg::CH_W-1:0]   ch,
    input  logic [pre_pkg::POS_W-1:0]  position,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [pre_pkg::ODD_W-1:0]  odd_radius,
    input  logic [pre_pkg::EVEN_W-1:0] even_radius,
    input  logic                       position_valid,
    input  logic                       overflow,
    output int unsigned                mismatches,
    output int unsigned                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pre_pkg::ODD_W-1:0]  odd;
        logic [pre_pkg::EVEN_W-1:0] even;
        logic                       pos_ok;
        logic                       ovf;
    } radii_t;

    // Shadow copy of the loaded string.
    logic [pre_pkg::CH_W-1:0] chars [pre_pkg::MAX_LEN];
    int              chars_len = 0;
    bit              dropped = 1'b0;

    radii_t          pending_radii [$];
    radii_t          due;
    int unsigned     fail_total = 0;
    int unsigned     pending_cnt = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_cnt;

    // Radii at one center, found by growing the palindrome pair by pair.
    function automatic radii_t radii_at(int pos);
        radii_t r;
        int     k;
        r = '0;
        r.ovf = dropped;
        if (pos <= chars_len) begin
            r.pos_ok = 1'b1;
            if (pos < chars_len) begin
                k = 0;
                while (pos - k - 1 >= 0 && pos + k + 1 < chars_len &&
                       chars[pos-k-1] == chars[pos+k+1])
                    k++;
                r.odd = pre_pkg::ODD_W'(k);
            end
            k = 0;
            while (pos - k - 1 >= 0 && pos + k < chars_len &&
                   chars[pos-k-1] == chars[pos+k])
                k++;
            r.even = pre_pkg::EVEN_W'(k);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [pre_pkg::EVEN_W-1:0] want,
                               logic [pre_pkg::EVEN_W-1:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t radii_check: %s expected %0d actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Results are checked before the same edge's input transfer is applied.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chars_len = 0;
            dropped = 1'b0;
            pending_radii.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (pending_radii.size() == 0) begin
                    fail_total++;
                    $display("%0t radii_check: result with none expected, odd %0d even %0d",
                             $time, odd_radius, even_radius);
                end else begin
                    due = pending_radii.pop_front();
                    check_field("odd_radius", pre_pkg::EVEN_W'(due.odd),
                                pre_pkg::EVEN_W'(odd_radius));
                    check_field("even_radius", due.even, even_radius);
                    check_field("position_valid", pre_pkg::EVEN_W'(due.pos_ok),
                                pre_pkg::EVEN_W'(position_valid));
                    check_field("overflow", pre_pkg::EVEN_W'(due.ovf),
                                pre_pkg::EVEN_W'(overflow));
                end
            end
            if (in_valid && in_ready) begin
                if (cmd == pre_pkg::CMD_APPEND) begin
                    if (restart) begin
                        chars_len = 0;
                        dropped = 1'b0;
                    end
                    if (chars_len < pre_pkg::MAX_LEN) begin
                        chars[chars_len] = ch;
                        chars_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end else begin
                    pending_radii.insert(pending_radii.size(), radii_at(int'(position)));
                end
            end
        end
        pending_cnt = pending_radii.size();
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS  = 240;
    localparam int MAX_BURST   = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES  = 64;

    typedef enum int {PH_STEADY, PH_TX_IDLE, PH_RX_STALL, PH_BOTH} phase_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd = pre_pkg::CMD_APPEND;
    logic                       restart = 1'b0;
    logic [pre_pkg::CH_W-1:0]   ch = '0;
    logic [pre_pkg::POS_W-1:0]  position = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [pre_pkg::ODD_W-1:0]  odd_radius;
    logic [pre_pkg::EVEN_W-1:0] even_radius;
    logic                       position_valid;
    logic                       overflow;

    int unsigned       mismatches;
    int unsigned       outstanding;

    phase_t            phase = PH_STEADY;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    bit                hold_done = 1'b0;
    int                items_sent = 0;
    int                cur_len = 0;

    always #5 clk = ~clk;

    palindrome_radius_engine_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .restart        (restart),
        .ch             (ch),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .odd_radius     (odd_radius),
        .even_radius    (even_radius),
        .position_valid (position_valid),
        .overflow       (overflow)
    );

    palindrome_radii_monitor radii_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .restart        (restart),
        .ch             (ch),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .odd_radius     (odd_radius),
        .even_radius    (even_radius),
        .position_valid (position_valid),
        .overflow       (overflow),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // One input transfer, with random idle cycles in front; called at a falling edge.
    task automatic send_item(logic c, logic r, logic [pre_pkg::CH_W-1:0] b,
                             logic [pre_pkg::POS_W-1:0] p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        restart <= r;
        ch <= b;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (c == pre_pkg::CMD_APPEND) begin
            if (r)
                cur_len = 0;
            if (cur_len < pre_pkg::MAX_LEN)
                cur_len++;
        end
    endtask

    // Unused fields carry random values so that their bits toggle too.
    task automatic append_char(logic r, logic [pre_pkg::CH_W-1:0] b);
        send_item(pre_pkg::CMD_APPEND, r, b, pre_pkg::POS_W'($urandom));
    endtask

    task automatic query_at(logic [pre_pkg::POS_W-1:0] p);
        send_item(pre_pkg::CMD_QUERY, 1'($urandom), pre_pkg::CH_W'($urandom), p);
    endtask

    // Load a short string rich in repeats or mirrored, then query around it.
    task automatic string_burst();
        int                       len;
        int                       nsym;
        int                       nq;
        int                       pick;
        int                       p;
        bit                       mirror;
        bit                       wide;
        bit                       fresh;
        logic [pre_pkg::CH_W-1:0] syms [3];
        logic [pre_pkg::CH_W-1:0] pattern [MAX_BURST];
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(1, 24);
        else if (pick < 95)
            len = $urandom_range(25, 64);
        else
            len = $urandom_range(65, MAX_BURST);
        nsym = $urandom_range(1, 3);
        wide = ($urandom_range(7) == 0);
        mirror = ($urandom_range(2) == 0);
        foreach (syms[i])
            syms[i] = pre_pkg::CH_W'($urandom);
        for (int i = 0; i < len; i++) begin
            if (mirror && i >= len / 2)
                pattern[i] = pattern[len-1-i];
            else if (wide)
                pattern[i] = pre_pkg::CH_W'($urandom);
            else
                pattern[i] = syms[$urandom_range(0, nsym - 1)];
        end
        // Most strings start fresh; the rest extend what is already loaded.
        fresh = (cur_len + len > 300) || ($urandom_range(9) != 0);
        for (int i = 0; i < len; i++) begin
            append_char(fresh && i == 0, pattern[i]);
            if ($urandom_range(9) == 0)
                query_at(pre_pkg::POS_W'($urandom_range(0, cur_len + 1)));
        end
        nq = $urandom_range(2, 8);
        for (int q = 0; q < nq; q++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                p = $urandom_range(0, cur_len + 1);
            end else if (pick < 85) begin
                p = cur_len;
            end else if (pick < 92) begin
                p = $urandom_range(0, 2047);
            end else begin
                append_char(1'b0, pattern[$urandom_range(0, len - 1)]);
                p = $urandom_range(0, cur_len);
            end
            query_at(pre_pkg::POS_W'(p));
        end
    endtask

    // Receiver: random stalls per phase, and one long hold-off that backs up the block.
    initial
    begin
        forever begin
            @(negedge clk);
            if (phase == PH_RX_STALL && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int first;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty string, an odd palindrome, extension, an even pair.
        query_at(pre_pkg::POS_W'(0));
        query_at(pre_pkg::POS_W'(1));
        query_at(pre_pkg::POS_W'(2047));
        append_char(1'b1, 8'hA5);
        append_char(1'b0, 8'h5A);
        append_char(1'b0, 8'h00);
        append_char(1'b0, 8'h5A);
        append_char(1'b0, 8'hA5);
        send_item(pre_pkg::CMD_QUERY, 1'b1, 8'hFF, pre_pkg::POS_W'(2));
        query_at(pre_pkg::POS_W'(5));
        query_at(pre_pkg::POS_W'(6));
        query_at(pre_pkg::POS_W'(0));
        append_char(1'b0, 8'hFF);
        query_at(pre_pkg::POS_W'(3));
        append_char(1'b1, 8'h00);
        append_char(1'b0, 8'h00);
        query_at(pre_pkg::POS_W'(1));
        query_at(pre_pkg::POS_W'(2));
        query_at(pre_pkg::POS_W'(1024));

        // Random bursts under each idling pattern.
        first = items_sent;
        for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
            phase = phase_t'(ph);
            case (phase)
                PH_STEADY:   begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                PH_TX_IDLE:  begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                PH_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default:     begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            while (items_sent - first < (ph + 1) * RAND_ITEMS / 4)
                string_burst();
        end

        // Full store: uniform string for the widest radii, then dropped appends.
        phase = PH_STEADY;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        for (int i = 0; i < pre_pkg::MAX_LEN + 2; i++)
            append_char(i == 0, 8'h3C);
        query_at(pre_pkg::POS_W'(0));
        query_at(pre_pkg::POS_W'(511));
        query_at(pre_pkg::POS_W'(512));
        query_at(pre_pkg::POS_W'(pre_pkg::MAX_LEN - 1));
        query_at(pre_pkg::POS_W'(pre_pkg::MAX_LEN));
        query_at(pre_pkg::POS_W'(pre_pkg::MAX_LEN + 1));
        query_at(pre_pkg::POS_W'($urandom_range(0, pre_pkg::MAX_LEN)));
        append_char(1'b1, 8'hC3);
        query_at(pre_pkg::POS_W'(0));
        query_at(pre_pkg::POS_W'(1));
        in_valid <= 1'b0;

        // Drain, then give any stray result time to show up.
        while (outstanding != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
